// ----- sv/dctr_pkg.sv -----
// Shared types and constants for the display color temperature ramp block.
package dctr_pkg;

    localparam int CH_W  = 9;
    localparam int CFG_W = 27;
    localparam int DIV_W = 24;
    localparam int DEN_W = 14;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_DAY       = 3'd1;
    localparam logic [2:0] REG_NIGHT     = 3'd2;
    localparam logic [2:0] REG_HOURS     = 3'd3;
    localparam logic [2:0] REG_RAMP_MIN  = 3'd4;
    localparam logic [2:0] REG_FADE_MIN  = 3'd5;
    localparam logic [2:0] REG_DIM       = 3'd6;
    localparam logic [2:0] REG_BL_WINDOW = 3'd7;

    localparam logic [1:0] MODE_OFF       = 2'd0;
    localparam logic [1:0] MODE_TIME      = 2'd1;
    localparam logic [1:0] MODE_BACKLIGHT = 2'd2;

    localparam logic [3:0] FACTOR_FULL = 4'd10;
    localparam logic [3:0] FACTOR_MIN  = 4'd2;

    typedef struct packed {
        logic       kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [9:0] backlight_level;
    } item_t;

    typedef struct packed {
        logic [8:0] red_scale;
        logic [8:0] green_scale;
        logic [8:0] blue_scale;
        logic       dim_active;
    } result_t;

    typedef enum logic [2:0] {
        MIX_DAY,
        MIX_NIGHT,
        MIX_RAMP,
        MIX_FADE,
        MIX_BLEND
    } mix_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE,
        S_RATE_WAIT,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_DIV_WAIT,
        S_SCALE,
        S_SCALE_WAIT,
        S_PUSH
    } state_t;

endpackage

// ----- sv/dctr_if.sv -----
// Valid/ready channel interfaces for input items and result beats.
interface dctr_item_if;
    logic            valid;
    logic            ready;
    dctr_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dctr_result_if;
    logic              valid;
    logic              ready;
    dctr_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/dctr_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module dctr_div #(
    parameter int DW = 24,
    parameter int VW = 14
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? VW'(trial - {1'b0, den_reg}) : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/display_color_temperature_ramp_core.sv -----
// Color temperature ramp: RGB panel gains from time ticks or backlight levels.
// An item that leaves the color as it is goes straight to push; one that recomputes it
// runs multiply, divide and scale per channel, after a rate division for a time ramp.
// A new item is taken only after the last is pushed; the shared 24-step divider does all.
// Reset: registers to their defaults, held color to day white, factor 10.
// The next item is taken while a finished result beat still waits.
module display_color_temperature_ramp_core #(
    parameter int SCALE_MAX     = 256,
    parameter int BACKLIGHT_MIN = 1,
    parameter int BACKLIGHT_MAX = 1023
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dctr_item_if.sink            item,
    dctr_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [26:0]          cfg_data
);

    function automatic logic [4:0] mod24(input logic [4:0] v);
        mod24 = (v >= 5'd24) ? 5'(v - 5'd24) : v;
    endfunction

    function automatic logic in_win(input logic [4:0] s, input logic [4:0] e,
                                    input logic [4:0] h);
        if (s < e)
            in_win = (h >= s) && (h < e);
        else if (s == e)
            in_win = 1'b0;
        else
            in_win = (h < e) || (h >= s);
    endfunction

    function automatic logic [4:0] hdiff(input logic [4:0] a, input logic [4:0] b);
        hdiff = (a >= b) ? 5'(a - b) : 5'(a + 5'd24 - b);
    endfunction

    // configuration
    logic [1:0]  mode_reg;
    logic [26:0] day_reg, night_reg;
    logic [9:0]  hours_reg;
    logic [10:0] ramp_min_reg, fade_min_reg;
    logic [14:0] dim_reg;
    logic [19:0] blwin_reg;

    // state
    logic [8:0]  held_reg [3];
    logic [3:0]  factor_reg, factor_next;
    logic [9:0]  last_bl_reg;
    dctr_pkg::state_t state_reg, state_next;
    dctr_pkg::mix_t   mix_reg, mix_next;
    logic [10:0] x_reg, x_next;
    logic [13:0] den_reg, den_next;
    logic [10:0] ramp_eff_reg, ramp_eff_next;
    logic [13:0] rate_reg;
    logic [1:0]  ch_reg;
    logic signed [35:0] prod_reg;
    logic [8:0]  v_reg;
    logic        out_valid_reg;
    dctr_pkg::result_t out_data_reg;

    logic        accept;
    logic        compute;
    logic [4:0]  hh, rs, re, ds, de, dh, sh;
    logic [5:0]  msat;
    logic        auto_dim;
    logic [3:0]  cfgf;
    logic [9:0]  lvl, bl, lo, hi;
    logic [10:0] active, since;
    logic signed [11:0] back;
    logic        push_go;

    logic        div_start, div_busy, div_done;
    logic [23:0] div_dividend, div_q;
    logic [13:0] div_divisor;

    logic [8:0]  d_ch, n_ch, base;
    logic signed [9:0]  diff;
    logic signed [21:0] prod1;
    logic signed [36:0] prod2;
    logic [35:0] mag;
    logic signed [11:0] vsum;

    assign accept  = item.valid && item.ready;
    assign hh      = mod24(item.data.hour);
    assign msat    = (item.data.minute > 6'd59) ? 6'd59 : item.data.minute;
    assign lvl     = item.data.backlight_level;
    assign auto_dim = dim_reg[4];
    assign cfgf    = (dim_reg[3:0] < dctr_pkg::FACTOR_MIN) ? dctr_pkg::FACTOR_MIN :
                     (dim_reg[3:0] > dctr_pkg::FACTOR_FULL) ? dctr_pkg::FACTOR_FULL :
                     dim_reg[3:0];
    assign rs      = mod24(hours_reg[9:5]);
    assign re      = mod24(hours_reg[4:0]);
    assign ds      = mod24(dim_reg[9:5]);
    assign de      = mod24(dim_reg[14:10]);
    assign dh      = hdiff(re, rs);
    assign sh      = hdiff(hh, rs);
    assign active  = 11'({6'd0, dh}) * 11'd60;
    assign since   = 11'({6'd0, sh}) * 11'd60 + 11'({5'd0, msat});
    assign back    = $signed({1'b0, active}) - $signed({1'b0, since});
    assign bl      = item.data.kind ? lvl : last_bl_reg;
    assign lo      = (blwin_reg[19:10] < blwin_reg[9:0]) ? blwin_reg[19:10] : blwin_reg[9:0];
    assign hi      = (blwin_reg[19:10] < blwin_reg[9:0]) ? blwin_reg[9:0] : blwin_reg[19:10];
    assign compute = !item.data.kind ||
                     ((lvl >= 10'(BACKLIGHT_MIN)) && (mode_reg == dctr_pkg::MODE_BACKLIGHT)
                      && (lvl <= 10'(BACKLIGHT_MAX)));

    // mix selection and operands for the accepted item
    always_comb
    begin
        mix_next      = dctr_pkg::MIX_DAY;
        x_next        = '0;
        den_next      = 14'd1;
        ramp_eff_next = (ramp_min_reg == 11'd0) ? 11'd1 : ramp_min_reg;
        if (!item.data.kind && (mode_reg == dctr_pkg::MODE_TIME))
        begin
            if (in_win(rs, re, hh))
            begin
                if ((back > $signed({1'b0, fade_min_reg})) || (fade_min_reg == 11'd0))
                begin
                    if (since >= ramp_eff_next)
                        mix_next = dctr_pkg::MIX_NIGHT;
                    else
                    begin
                        mix_next = dctr_pkg::MIX_RAMP;
                        x_next   = since;
                        den_next = 14'(active) * 14'd10;
                    end
                end
                else
                begin
                    mix_next = dctr_pkg::MIX_FADE;
                    x_next   = 11'(fade_min_reg - back[10:0]);
                    den_next = 14'(fade_min_reg);
                end
            end
        end
        else if (mode_reg == dctr_pkg::MODE_BACKLIGHT)
        begin
            if (bl > hi)
                mix_next = dctr_pkg::MIX_DAY;
            else if (bl <= lo)
                mix_next = dctr_pkg::MIX_NIGHT;
            else
            begin
                mix_next = dctr_pkg::MIX_BLEND;
                x_next   = 11'(hi - bl);
                den_next = 14'(hi - lo);
            end
        end
    end

    always_comb
    begin
        factor_next = factor_reg;
        if (!item.data.kind)
            factor_next = (auto_dim && !in_win(ds, de, hh)) ? dctr_pkg::FACTOR_FULL : cfgf;
        else if (!auto_dim)
            factor_next = cfgf;
    end

    // channel datapath
    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                d_ch = day_reg[26:18];
                n_ch = night_reg[26:18];
            end
            2'd1:
            begin
                d_ch = day_reg[17:9];
                n_ch = night_reg[17:9];
            end
            default:
            begin
                d_ch = day_reg[8:0];
                n_ch = night_reg[8:0];
            end
        endcase
    end

    assign base  = ((mix_reg == dctr_pkg::MIX_NIGHT) || (mix_reg == dctr_pkg::MIX_FADE)) ?
                   n_ch : d_ch;
    assign diff  = (mix_reg == dctr_pkg::MIX_FADE) ?
                   $signed({1'b0, d_ch}) - $signed({1'b0, n_ch}) :
                   $signed({1'b0, n_ch}) - $signed({1'b0, d_ch});
    assign prod1 = diff * $signed({1'b0, x_reg});
    assign prod2 = $signed(prod_reg[21:0]) * $signed({1'b0, rate_reg});
    assign mag   = prod_reg[35] ? 36'(-prod_reg) : 36'(prod_reg);
    assign vsum  = prod_reg[35] ? $signed({3'b0, base}) - $signed({1'b0, div_q[10:0]}) :
                                  $signed({3'b0, base}) + $signed({1'b0, div_q[10:0]});
    assign push_go = !out_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dctr_pkg::S_IDLE:
                if (accept)
                begin
                    if (!compute)
                        state_next = dctr_pkg::S_PUSH;
                    else if (mix_next == dctr_pkg::MIX_RAMP)
                        state_next = dctr_pkg::S_RATE;
                    else
                        state_next = dctr_pkg::S_MUL1;
                end
            dctr_pkg::S_RATE:      state_next = dctr_pkg::S_RATE_WAIT;
            dctr_pkg::S_RATE_WAIT: if (div_done) state_next = dctr_pkg::S_MUL1;
            dctr_pkg::S_MUL1:      state_next = dctr_pkg::S_MUL2;
            dctr_pkg::S_MUL2:      state_next = dctr_pkg::S_DIV;
            dctr_pkg::S_DIV:       state_next = dctr_pkg::S_DIV_WAIT;
            dctr_pkg::S_DIV_WAIT:  if (div_done) state_next = dctr_pkg::S_SCALE;
            dctr_pkg::S_SCALE:     state_next = dctr_pkg::S_SCALE_WAIT;
            dctr_pkg::S_SCALE_WAIT:
                if (div_done)
                    state_next = (ch_reg == 2'd2) ? dctr_pkg::S_PUSH : dctr_pkg::S_MUL1;
            dctr_pkg::S_PUSH:      if (push_go) state_next = dctr_pkg::S_IDLE;
            default:               state_next = dctr_pkg::S_IDLE;
        endcase
    end

    // divider operands
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 14'd1;
        case (state_reg)
            dctr_pkg::S_RATE:
            begin
                div_start    = 1'b1;
                div_dividend = 24'(den_reg);
                div_divisor  = 14'(ramp_eff_reg);
            end
            dctr_pkg::S_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = mag[23:0];
                div_divisor  = den_reg;
            end
            dctr_pkg::S_SCALE:
            begin
                div_start    = 1'b1;
                div_dividend = 24'(v_reg) * 24'(factor_reg);
                div_divisor  = 14'd10;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    dctr_div #(
        .DW (dctr_pkg::DIV_W),
        .VW (dctr_pkg::DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dctr_pkg::S_IDLE;
            mode_reg      <= 2'd0;
            day_reg       <= 27'd67240192;
            night_reg     <= 27'd67212439;
            hours_reg     <= 10'd551;
            ramp_min_reg  <= 11'd300;
            fade_min_reg  <= 11'd60;
            dim_reg       <= 15'd6890;
            blwin_reg     <= 20'd524352;
            held_reg[0]   <= 9'd256;
            held_reg[1]   <= 9'd256;
            held_reg[2]   <= 9'd256;
            factor_reg    <= dctr_pkg::FACTOR_FULL;
            last_bl_reg   <= 10'(BACKLIGHT_MAX);
            ch_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dctr_pkg::REG_MODE:      mode_reg     <= cfg_data[1:0];
                    dctr_pkg::REG_DAY:       day_reg      <= cfg_data;
                    dctr_pkg::REG_NIGHT:     night_reg    <= cfg_data;
                    dctr_pkg::REG_HOURS:     hours_reg    <= cfg_data[9:0];
                    dctr_pkg::REG_RAMP_MIN:  ramp_min_reg <= cfg_data[10:0];
                    dctr_pkg::REG_FADE_MIN:  fade_min_reg <= cfg_data[10:0];
                    dctr_pkg::REG_DIM:       dim_reg      <= cfg_data[14:0];
                    dctr_pkg::REG_BL_WINDOW: blwin_reg    <= cfg_data[19:0];
                    default:                 mode_reg     <= mode_reg;
                endcase
            end
            if (accept)
            begin
                factor_reg <= factor_next;
                ch_reg     <= 2'd0;
                if (item.data.kind && (lvl >= 10'(BACKLIGHT_MIN)))
                    last_bl_reg <= lvl;
            end
            if ((state_reg == dctr_pkg::S_SCALE_WAIT) && div_done)
            begin
                held_reg[ch_reg] <= (div_q > 24'(SCALE_MAX)) ? 9'(SCALE_MAX) : div_q[8:0];
                ch_reg           <= 2'(ch_reg + 2'd1);
            end
            if ((state_reg == dctr_pkg::S_PUSH) && push_go)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mix_reg      <= mix_next;
            x_reg        <= x_next;
            den_reg      <= den_next;
            ramp_eff_reg <= ramp_eff_next;
        end
        if ((state_reg == dctr_pkg::S_RATE_WAIT) && div_done)
            rate_reg <= div_q[13:0];
        if (state_reg == dctr_pkg::S_MUL1)
            prod_reg <= {{14{prod1[21]}}, prod1};
        if ((state_reg == dctr_pkg::S_MUL2) && (mix_reg == dctr_pkg::MIX_RAMP))
            prod_reg <= prod2[35:0];
        if ((state_reg == dctr_pkg::S_DIV_WAIT) && div_done)
            v_reg <= vsum[11] ? 9'd0 : vsum[8:0];
        if ((state_reg == dctr_pkg::S_PUSH) && push_go)
        begin
            out_data_reg.red_scale   <= held_reg[0];
            out_data_reg.green_scale <= held_reg[1];
            out_data_reg.blue_scale  <= held_reg[2];
            out_data_reg.dim_active  <= factor_reg < dctr_pkg::FACTOR_FULL;
        end
    end

    assign item.ready   = (state_reg == dctr_pkg::S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dctr_pkg::S_PUSH) && push_go |=>
        out_valid_reg && (state_reg == dctr_pkg::S_IDLE))
        else $error("result beat not loaded");

    a_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != dctr_pkg::S_IDLE) && (state_reg != dctr_pkg::S_PUSH) |->
        (ch_reg != 2'd3))
        else $error("channel index out of range");

endmodule
